FILE: rtl/bfea_pkg.sv
// shared types and constants for the best-fit extent allocator
// no dependencies; imported by bfea_round and best_fit_extent_allocator_unit
`timescale 1ns / 1ps

package bfea_pkg;

  localparam int DataW        = 32;
  localparam int ExtentsDef   = 64;
  localparam int PageBytesDef = 4096;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_SUPPLY = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NOFIT = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_FIXED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_SCAN,
    ST_FINISH,
    ST_COMPACT,
    ST_RESP
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [DataW-1:0]  req_addr;
    logic [DataW-1:0]  size_bytes;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]  grant_addr;
    status_e           status;
  } rsp_t;

  typedef struct packed {
    logic              start;
    logic [DataW-1:0]  value;
  } rnd_req_t;

  typedef struct packed {
    logic              done;
    logic [DataW-1:0]  rounded;
  } rnd_rsp_t;

endpackage

FILE: rtl/best_fit_extent_allocator_unit.sv
// top level of the best-fit extent allocator: sequencer, extent memory, result register
// depends on bfea_pkg and bfea_round
`timescale 1ns / 1ps

// usage
//   request channel: in_valid_i / in_stall_o carry req_t (func, req_addr, size_bytes);
//   a transfer happens on a clock edge with valid high and stall low
//   result channel: out_valid_o / out_stall_i carry rsp_t (grant_addr, status),
//   exactly one result transfer per request transfer, in order
//   one request is worked on at a time; in_stall_o is high while it is busy
//   steps per request:
//     alloc / free: page rounding, a scan of up to all held extents, a decide step,
//     compaction after a removal, then loading of the result
//     supply raw bytes: as above without the rounding step
//     refused alloc and the unused func code: straight to loading of the result
//   the scan over the extent memory (one read port, one entry a cycle) and the
//   compaction after a removal (one entry moved a cycle) are the longest steps
//   the result sits in an output register; a new request is taken while it waits,
//   and the block holds its next result until the receiver lets the old one go
//   reset empties the table (count to zero), drops any pending result;
//   extent memory contents are not cleared

module best_fit_extent_allocator_unit
  import bfea_pkg::*;
#(
  parameter int EXTENTS    = ExtentsDef,
  parameter int PAGE_BYTES = PageBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int IdxW = (EXTENTS > 1) ? $clog2(EXTENTS) : 1;
  localparam int CntW = $clog2(EXTENTS + 1);
  localparam int EntW = 2 * DataW;

  // control state
  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] rd_q;
  logic            pv_q;
  logic [CntW-1:0] pidx_q;
  logic            found_q, hf_q, hb_q;
  logic            out_valid_q;

  // payload state
  req_t            req_q;
  logic [DataW-1:0] size_q;
  logic [IdxW-1:0] best_q, front_q, back_q;
  logic [DataW-1:0] best_len_q, best_start_q;
  logic [DataW-1:0] fs_q, fl_q, bs_q, bl_q;
  rsp_t            res_q;
  rsp_t            out_q;

  // extent memory: bits 63..32 length, bits 31..0 start
  logic [EntW-1:0] mem [EXTENTS];
  logic [EntW-1:0] rdata_q;

  logic            accept;
  logic            is_alloc;
  logic [DataW-1:0] rd_len, rd_start;
  logic            al_ge, al_eq, al_better;
  logic            sp_f, sp_b;
  logic            rd_issue;
  logic            scan_stop;
  logic            resp_load;

  // per-state controls
  logic            mem_re, mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [EntW-1:0] mem_wdata;
  logic            fin_remove, fin_append;
  logic [IdxW-1:0] fin_rm_idx;
  status_e         fin_status;
  logic [DataW-1:0] fin_grant;
  logic [DataW-1:0] alloc_rest;

  rnd_req_t        rnd_req;
  rnd_rsp_t        rnd_rsp;

  bfea_round #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_round (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rnd_req),
    .rsp_o (rnd_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign resp_load   = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  // rounding starts right at the request transfer
  assign rnd_req.start = accept && ((in_req_i.func == FUNC_FREE) ||
                         ((in_req_i.func == FUNC_ALLOC) && (in_req_i.req_addr == '0)));
  assign rnd_req.value = in_req_i.size_bytes;

  // entry under test, one read behind the read pointer
  assign is_alloc  = (req_q.func == FUNC_ALLOC);
  assign rd_len    = rdata_q[EntW-1:DataW];
  assign rd_start  = rdata_q[DataW-1:0];
  assign al_ge     = (rd_len >= size_q);
  assign al_eq     = (rd_len == size_q);
  assign al_better = !found_q || (best_len_q > rd_len);
  assign sp_f      = ((rd_start + rd_len) == req_q.req_addr);
  assign sp_b      = (rd_start == (req_q.req_addr + size_q));
  assign rd_issue  = (rd_q < cnt_q);

  // exact fit ends an alloc scan; a merge scan ends once both sides matched
  assign scan_stop = pv_q && (is_alloc ? (al_ge && al_eq) :
                     ((sp_f && hb_q) || (sp_b && (hf_q || sp_f))));

  assign alloc_rest = best_len_q - size_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_i.func)
            FUNC_ALLOC: begin
              state_d = (in_req_i.req_addr != '0) ? ST_RESP : ST_ROUND;
            end
            FUNC_FREE:   state_d = ST_ROUND;
            FUNC_SUPPLY: state_d = ST_SCAN;
            default:     state_d = ST_RESP;
          endcase
        end
      end
      ST_ROUND: begin
        if (rnd_rsp.done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_stop || (!rd_issue && !pv_q)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = fin_remove ? ST_COMPACT : ST_RESP;
      end
      ST_COMPACT: begin
        if (!rd_issue && !pv_q) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (resp_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of each state: memory controls and the end-of-scan decision
  always_comb begin
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    fin_remove = 1'b0;
    fin_append = 1'b0;
    fin_rm_idx = '0;
    fin_status = STATUS_OK;
    fin_grant  = '0;
    case (state_q)
      ST_SCAN: begin
        mem_re = rd_issue;
      end
      ST_FINISH: begin
        if (is_alloc) begin
          if (!found_q) begin
            fin_status = STATUS_NOFIT;
          end else begin
            fin_grant = best_start_q;
            if (alloc_rest == '0) begin
              fin_remove = 1'b1;
              fin_rm_idx = best_q;
            end else begin
              // shrink from the front
              mem_we    = 1'b1;
              mem_waddr = best_q;
              mem_wdata = {alloc_rest, best_start_q + size_q};
            end
          end
        end else if (hf_q) begin
          mem_we    = 1'b1;
          mem_waddr = front_q;
          if (hb_q) begin
            // bridge both neighbours, then drop the upper one
            mem_wdata  = {fl_q + size_q + bl_q, fs_q};
            fin_remove = 1'b1;
            fin_rm_idx = back_q;
          end else begin
            mem_wdata = {fl_q + size_q, fs_q};
          end
        end else if (hb_q) begin
          mem_we    = 1'b1;
          mem_waddr = back_q;
          mem_wdata = {bl_q + size_q, bs_q - size_q};
        end else if (cnt_q == CntW'(EXTENTS)) begin
          fin_status = STATUS_FULL;
        end else begin
          // append at the tail
          mem_we     = 1'b1;
          mem_waddr  = cnt_q[IdxW-1:0];
          mem_wdata  = {size_q, req_q.req_addr};
          fin_append = 1'b1;
        end
      end
      ST_COMPACT: begin
        mem_re = rd_issue;
        if (pv_q) begin
          // move the entry just read down by one place
          mem_we    = 1'b1;
          mem_waddr = IdxW'(pidx_q - CntW'(1));
          mem_wdata = rdata_q;
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // extent memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[rd_q[IdxW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_q        <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      hf_q        <= 1'b0;
      hb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          rd_q    <= '0;
          pv_q    <= 1'b0;
          found_q <= 1'b0;
          hf_q    <= 1'b0;
          hb_q    <= 1'b0;
        end
        ST_SCAN: begin
          rd_q   <= rd_q + CntW'(rd_issue);
          pv_q   <= rd_issue;
          pidx_q <= rd_q;
          if (pv_q) begin
            if (is_alloc) begin
              if (al_ge && (al_eq || al_better)) found_q <= 1'b1;
            end else begin
              if (sp_f) hf_q <= 1'b1;
              if (sp_b && !(sp_f && hb_q)) hb_q <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          rd_q <= CntW'(fin_rm_idx) + CntW'(1);
          pv_q <= 1'b0;
          if (fin_append) cnt_q <= cnt_q + CntW'(1);
        end
        ST_COMPACT: begin
          rd_q   <= rd_q + CntW'(rd_issue);
          pv_q   <= rd_issue;
          pidx_q <= rd_q;
          if (!rd_issue && !pv_q) cnt_q <= cnt_q - CntW'(1);
        end
        default: begin
          pv_q <= 1'b0;
        end
      endcase
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_q            <= in_req_i;
          size_q           <= in_req_i.size_bytes;
          res_q.grant_addr <= '0;
          if ((in_req_i.func == FUNC_ALLOC) && (in_req_i.req_addr != '0)) begin
            res_q.status <= STATUS_FIXED;
          end else begin
            res_q.status <= STATUS_OK;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_rsp.done) size_q <= rnd_rsp.rounded;
      end
      ST_SCAN: begin
        if (pv_q) begin
          if (is_alloc) begin
            if (al_ge && (al_eq || al_better)) begin
              best_q       <= pidx_q[IdxW-1:0];
              best_len_q   <= rd_len;
              best_start_q <= rd_start;
            end
          end else begin
            if (sp_f) begin
              front_q <= pidx_q[IdxW-1:0];
              fs_q    <= rd_start;
              fl_q    <= rd_len;
            end
            if (sp_b && !(sp_f && hb_q)) begin
              back_q <= pidx_q[IdxW-1:0];
              bs_q   <= rd_start;
              bl_q   <= rd_len;
            end
          end
        end
      end
      ST_FINISH: begin
        res_q.grant_addr <= fin_grant;
        res_q.status     <= fin_status;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
    if (resp_load) out_q <= res_q;
  end

endmodule

FILE: rtl/bfea_round.sv
// page rounding unit: rounds a byte count up to whole pages with an add and a mask
// depends on bfea_pkg; the page size must be a power of two, which the block does not check
`timescale 1ns / 1ps

module bfea_round
  import bfea_pkg::*;
#(
  parameter int PAGE_BYTES = PageBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rnd_req_t req_i,
  output rnd_rsp_t rsp_o
);

  localparam logic [DataW-1:0] PageMask = DataW'(PAGE_BYTES - 1);

  logic [DataW-1:0] sum;
  logic [DataW-1:0] rounded_q;
  logic             done_q;

  // low bits below the page size hold the remainder; the add wraps at the data width
  assign sum = req_i.value + PageMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) rounded_q <= sum & ~PageMask;
  end

  // result and done are registered from the start pulse and show in the next cycle
  assign rsp_o.done    = done_q;
  assign rsp_o.rounded = rounded_q;

endmodule
